@@ src/bgc_pkg.sv @@
// Package for the button gesture classifier.
// Holds state and event codes and the shared item and register structs.
// No dependencies.
package bgc_pkg;

  localparam int unsigned StateW = 4;
  localparam int unsigned EventW = 3;
  localparam int unsigned MsW    = 16;
  localparam int unsigned CfgIdxW = 1;

  // Classifier state codes.
  localparam logic [StateW-1:0] S_IDLE    = 4'd0;
  localparam logic [StateW-1:0] S_P1      = 4'd1;
  localparam logic [StateW-1:0] S_R1      = 4'd2;
  localparam logic [StateW-1:0] S_P2      = 4'd3;
  localparam logic [StateW-1:0] S_LSTART  = 4'd4;
  localparam logic [StateW-1:0] S_LHELD   = 4'd5;
  localparam logic [StateW-1:0] S_DLSTART = 4'd6;
  localparam logic [StateW-1:0] S_DLHELD  = 4'd7;
  localparam logic [StateW-1:0] S_SHORT   = 4'd8;
  localparam logic [StateW-1:0] S_DOUBLE  = 4'd9;

  // Gesture event codes.
  localparam logic [EventW-1:0] EV_IDLE    = 3'd0;
  localparam logic [EventW-1:0] EV_SHORT   = 3'd1;
  localparam logic [EventW-1:0] EV_DOUBLE  = 3'd2;
  localparam logic [EventW-1:0] EV_LSTART  = 3'd3;
  localparam logic [EventW-1:0] EV_LHELD   = 3'd4;
  localparam logic [EventW-1:0] EV_DLSTART = 3'd5;
  localparam logic [EventW-1:0] EV_DLHELD  = 3'd6;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS  = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_RELEASE_GAP = 1'd1;

  localparam logic [MsW-1:0] LongPressReset  = 16'd500;
  localparam logic [MsW-1:0] ReleaseGapReset = 16'd300;
  localparam logic [MsW-1:0] MsMax           = 16'hFFFF;

  // One input item.
  typedef struct packed {
    logic action;   // 1 = force idle
    logic pressed;
  } item_t;

  // Threshold registers.
  typedef struct packed {
    logic [MsW-1:0] long_press_ms;
    logic [MsW-1:0] release_gap_ms;
  } cfg_t;

  // Map a state to the event it reports.
  function automatic logic [EventW-1:0] event_of(input logic [StateW-1:0] s);
    logic [EventW-1:0] ev;
    unique case (s)
      S_SHORT:   ev = EV_SHORT;
      S_DOUBLE:  ev = EV_DOUBLE;
      S_LSTART:  ev = EV_LSTART;
      S_LHELD:   ev = EV_LHELD;
      S_DLSTART: ev = EV_DLSTART;
      S_DLHELD:  ev = EV_DLHELD;
      default:   ev = EV_IDLE;
    endcase
    return ev;
  endfunction

endpackage

@@ src/bgc_cfg_regs.sv @@
// Threshold registers of the button gesture classifier.
// Depends on bgc_pkg.
module bgc_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        we_i,
  input  logic [bgc_pkg::CfgIdxW-1:0] idx_i,
  input  logic [bgc_pkg::MsW-1:0]     data_i,
  output bgc_pkg::cfg_t               cfg_o
);

  bgc_pkg::cfg_t cfg_q, cfg_d;

  // Decode the register index on a write.
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        bgc_pkg::REG_LONG_PRESS:  cfg_d.long_press_ms  = data_i;
        bgc_pkg::REG_RELEASE_GAP: cfg_d.release_gap_ms = data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ms  <= bgc_pkg::LongPressReset;
      cfg_q.release_gap_ms <= bgc_pkg::ReleaseGapReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/bgc_fsm.sv @@
// Gesture state machine and millisecond counter.
// Depends on bgc_pkg. Updates on step_i and reports the event of the new state.
module bgc_fsm (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  bgc_pkg::item_t             item_i,
  input  bgc_pkg::cfg_t              cfg_i,
  output logic [bgc_pkg::EventW-1:0] event_o,
  output logic [bgc_pkg::StateW-1:0] state_o
);

  logic [bgc_pkg::StateW-1:0] state_q, state_d;
  logic [bgc_pkg::MsW-1:0]    ms_q, ms_d;
  logic [bgc_pkg::MsW-1:0]    ms_inc;
  logic                       down;
  logic                       go;
  logic [bgc_pkg::StateW-1:0] target;
  logic                       long_hit;
  logic                       gap_hit;

  // Saturating tick count and the two strict threshold compares.
  assign ms_inc   = (ms_q == bgc_pkg::MsMax) ? ms_q : ms_q + 1'b1;
  assign long_hit = ms_inc > cfg_i.long_press_ms;
  assign gap_hit  = ms_inc > cfg_i.release_gap_ms;
  assign down     = item_i.pressed;

  // Transition decision for one tick.
  always_comb begin
    go     = 1'b0;
    target = state_q;
    unique case (state_q)
      bgc_pkg::S_P1: begin
        if (!down) begin
          go = 1'b1; target = bgc_pkg::S_R1;
        end else if (long_hit) begin
          go = 1'b1; target = bgc_pkg::S_LSTART;
        end
      end
      bgc_pkg::S_R1: begin
        if (down) begin
          go = 1'b1; target = bgc_pkg::S_P2;
        end else if (gap_hit) begin
          go = 1'b1; target = bgc_pkg::S_SHORT;
        end
      end
      bgc_pkg::S_P2: begin
        if (!down) begin
          go = 1'b1; target = bgc_pkg::S_DOUBLE;
        end else if (long_hit) begin
          go = 1'b1; target = bgc_pkg::S_DLSTART;
        end
      end
      bgc_pkg::S_LSTART: begin
        go     = 1'b1;
        target = down ? bgc_pkg::S_LHELD : bgc_pkg::S_IDLE;
      end
      bgc_pkg::S_DLSTART: begin
        go     = 1'b1;
        target = down ? bgc_pkg::S_DLHELD : bgc_pkg::S_IDLE;
      end
      bgc_pkg::S_LHELD, bgc_pkg::S_DLHELD: begin
        if (!down) begin
          go = 1'b1; target = bgc_pkg::S_IDLE;
        end
      end
      bgc_pkg::S_SHORT, bgc_pkg::S_DOUBLE: begin
        go = 1'b1; target = bgc_pkg::S_IDLE;
      end
      default: begin
        // Idle and the unreachable codes act as idle.
        if (down) begin
          go = 1'b1; target = bgc_pkg::S_P1;
        end
      end
    endcase
  end

  // Force idle overrides the tick; any transition clears the counter.
  always_comb begin
    state_d = state_q;
    ms_d    = ms_q;
    if (step_i) begin
      if (item_i.action) begin
        state_d = bgc_pkg::S_IDLE;
        ms_d    = '0;
      end else if (go) begin
        state_d = target;
        ms_d    = '0;
      end else begin
        ms_d = ms_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bgc_pkg::S_IDLE;
      ms_q    <= '0;
    end else begin
      state_q <= state_d;
      ms_q    <= ms_d;
    end
  end

  assign event_o = bgc_pkg::event_of(state_d);
  assign state_o = state_q;

endmodule

@@ src/button_gesture_classifier.sv @@
// Top level of the button gesture classifier.
// Depends on bgc_pkg, bgc_cfg_regs and bgc_fsm.
//
// Feed one transaction per millisecond tick; each accepted input transaction
// yields exactly one output transaction carrying the gesture event of the
// state the tick leaves the machine in. The block takes one transaction per
// clock unless the output stalls: an input register feeds the state machine,
// whose next state and event are combinational, and the event lands in an
// output register. Input ready drops only when both registers are full and
// the output is stalled. The user must see that thresholds are written through
// the configuration port while no transaction is in flight; the block does not
// enforce it. A threshold of 65535 disables that timeout.
module button_gesture_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] pressed, [7:1] zero
  input  logic [0:0]  s_axis_tuser,   // [0] action (1 = force idle)
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [2:0] gesture_event, [7:3] zero
  // Configuration writes.
  input  logic        cfg_we_i,
  input  logic [bgc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bgc_pkg::MsW-1:0]     cfg_data_i
);

  bgc_pkg::cfg_t              cfg;
  bgc_pkg::item_t             item_q;
  logic                       in_valid_q;
  logic                       out_valid_q;
  logic [bgc_pkg::EventW-1:0] event_q;
  logic [bgc_pkg::EventW-1:0] next_event;
  logic [bgc_pkg::StateW-1:0] fsm_state;
  logic                       advance;
  logic                       in_take;

  // The held item moves on when the output register is free or draining.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.action  <= s_axis_tuser[0];
      item_q.pressed <= s_axis_tdata[0];
    end
  end

  bgc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  bgc_fsm u_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .item_i  (item_q),
    .cfg_i   (cfg),
    .event_o (next_event),
    .state_o (fsm_state)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      event_q <= next_event;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, event_q};

  // A held item that cannot move on stays held.
  a_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("input item lost while output stalled");

  // Every advance produces a pending output transaction.
  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced item produced no output");

  // A stalled result is not overwritten.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> out_valid_q && $stable(event_q))
    else $error("stalled result changed");

  // Long start always follows a first press.
  a_lstart_from_p1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(advance) && fsm_state == bgc_pkg::S_LSTART |->
      $past(fsm_state) == bgc_pkg::S_P1)
    else $error("long start entered from wrong state");

endmodule
